/* hdl/volume_brick_max_reduce_top_assert.svh */
// Assertion macros for the brick max reduce checker
`ifndef VOLUME_BRICK_MAX_REDUCE_TOP_ASSERT_SVH
`define VOLUME_BRICK_MAX_REDUCE_TOP_ASSERT_SVH

// same-cycle implication
`define VBMR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vbmr assertion failed");

// next-cycle implication
`define VBMR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vbmr assertion failed");

`endif

/* hdl/vbmr_pkg.sv */
package vbmr_pkg;

   localparam int unsigned BRICK_IDX_W = 6;
   localparam int unsigned ADDR_W      = 2 * BRICK_IDX_W;
   localparam int unsigned MEM_DEPTH   = 1 << ADDR_W;
   localparam int unsigned MAX_W       = 31;
   localparam int unsigned CSR_ADDR_W  = 4;

   localparam logic [31:0] POS_INF_BITS = 32'h7F80_0000;
   localparam logic [5:0]  MIN_BRICK    = 6'd2;
   localparam logic [5:0]  MAX_BRICK    = 6'd32;
   localparam logic [5:0]  RESET_BRICK  = 6'd8;
   localparam logic [8:0]  MIN_DIM      = 9'd1;
   localparam logic [8:0]  MAX_DIM      = 9'd256;

   localparam logic [1:0] REG_BRICK_SIZE = 2'd0;
   localparam logic [1:0] REG_DIM_X      = 2'd1;
   localparam logic [1:0] REG_DIM_Y      = 2'd2;
   localparam logic [1:0] REG_DIM_Z      = 2'd3;

   typedef struct packed {
      logic [5:0] brick_size;
      logic [8:0] dim_x;
      logic [8:0] dim_y;
      logic [8:0] dim_z;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0]      addr;
      logic                   write;
      logic                   first;
      logic                   emit;
      logic                   last;
      logic [BRICK_IDX_W-1:0] bx;
      logic [BRICK_IDX_W-1:0] by;
      logic [BRICK_IDX_W-1:0] bz;
      logic [MAX_W-1:0]       dens;
   } voxel_info_type;

endpackage

/* hdl/vbmr_walker.sv */
module vbmr_walker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     restart,
   input  logic                     advance,
   input  vbmr_pkg::cfg_type        cfg,
   input  logic [31:0]              density_bits,
   output vbmr_pkg::voxel_info_type info
);

   logic [7:0] vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   logic [4:0] ox_ff, ox_in, oy_ff, oy_in, oz_ff, oz_in;
   logic [6:0] bx_ff, bx_in, by_ff, by_in, bz_ff, bz_in;

   logic row_end, col_end, vol_end;
   logic ox_wrap, oy_wrap, oz_wrap;
   logic end_x, end_y, end_z;
   logic in_range, last_x, last_y, last_z;

   always_comb begin
      row_end = ({1'b0, vx_ff} + 9'd1) >= cfg.dim_x;
      col_end = ({1'b0, vy_ff} + 9'd1) >= cfg.dim_y;
      vol_end = ({1'b0, vz_ff} + 9'd1) >= cfg.dim_z;
      ox_wrap = ({1'b0, ox_ff} + 6'd1) >= cfg.brick_size;
      oy_wrap = ({1'b0, oy_ff} + 6'd1) >= cfg.brick_size;
      oz_wrap = ({1'b0, oz_ff} + 6'd1) >= cfg.brick_size;
      end_x = row_end || ox_wrap;
      end_y = col_end || oy_wrap;
      end_z = vol_end || oz_wrap;
      in_range = !bx_ff[6] && !by_ff[6] && !bz_ff[6];
      // a finished brick is last on an axis if it holds the volume edge or the index limit
      last_x = row_end || (bx_ff[5:0] == 6'h3F);
      last_y = col_end || (by_ff[5:0] == 6'h3F);
      last_z = vol_end || (bz_ff[5:0] == 6'h3F);

      info.addr  = {by_ff[5:0], bx_ff[5:0]};
      info.write = in_range;
      info.first = (ox_ff == 5'd0) && (oy_ff == 5'd0) && (oz_ff == 5'd0);
      info.emit  = in_range && end_x && end_y && end_z;
      info.last  = last_x && last_y && last_z;
      info.bx    = bx_ff[5:0];
      info.by    = by_ff[5:0];
      info.bz    = bz_ff[5:0];
      info.dens  = (density_bits <= vbmr_pkg::POS_INF_BITS) ? density_bits[30:0] : 31'd0;
   end

   always_comb begin
      vx_in = vx_ff; vy_in = vy_ff; vz_in = vz_ff;
      ox_in = ox_ff; oy_in = oy_ff; oz_in = oz_ff;
      bx_in = bx_ff; by_in = by_ff; bz_in = bz_ff;
      if (restart) begin
         vx_in = '0; vy_in = '0; vz_in = '0;
         ox_in = '0; oy_in = '0; oz_in = '0;
         bx_in = '0; by_in = '0; bz_in = '0;
      end else if (advance) begin
         if (!row_end) begin
            vx_in = vx_ff + 8'd1;
            ox_in = ox_wrap ? 5'd0 : ox_ff + 5'd1;
            bx_in = ox_wrap ? bx_ff + 7'd1 : bx_ff;
         end else begin
            vx_in = '0; ox_in = '0; bx_in = '0;
            if (!col_end) begin
               vy_in = vy_ff + 8'd1;
               oy_in = oy_wrap ? 5'd0 : oy_ff + 5'd1;
               by_in = oy_wrap ? by_ff + 7'd1 : by_ff;
            end else begin
               vy_in = '0; oy_in = '0; by_in = '0;
               if (!vol_end) begin
                  vz_in = vz_ff + 8'd1;
                  oz_in = oz_wrap ? 5'd0 : oz_ff + 5'd1;
                  bz_in = oz_wrap ? bz_ff + 7'd1 : bz_ff;
               end else begin
                  vz_in = '0; oz_in = '0; bz_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vx_ff <= '0; vy_ff <= '0; vz_ff <= '0;
         ox_ff <= '0; oy_ff <= '0; oz_ff <= '0;
         bx_ff <= '0; by_ff <= '0; bz_ff <= '0;
      end else begin
         vx_ff <= vx_in; vy_ff <= vy_in; vz_ff <= vz_in;
         ox_ff <= ox_in; oy_ff <= oy_in; oz_ff <= oz_in;
         bx_ff <= bx_in; by_ff <= by_in; bz_ff <= bz_in;
      end
   end

endmodule

/* hdl/vbmr_reduce.sv */
module vbmr_reduce (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  vbmr_pkg::voxel_info_type             info,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [vbmr_pkg::BRICK_IDX_W-1:0]     rsp_brick_x,
   output logic [vbmr_pkg::BRICK_IDX_W-1:0]     rsp_brick_y,
   output logic [vbmr_pkg::BRICK_IDX_W-1:0]     rsp_brick_z,
   output logic [vbmr_pkg::MAX_W-1:0]           rsp_brick_max_bits,
   output logic                                 rsp_last_brick
);

   logic [vbmr_pkg::MAX_W-1:0] mem [vbmr_pkg::MEM_DEPTH];

   logic                            s1_vld_ff, s1_vld_in;
   vbmr_pkg::voxel_info_type        s1_ff;
   logic [vbmr_pkg::MAX_W-1:0]      rd_data_ff;
   logic                            fwd_vld_ff, fwd_vld_in;
   logic [vbmr_pkg::ADDR_W-1:0]     fwd_addr_ff;
   logic [vbmr_pkg::MAX_W-1:0]      fwd_data_ff;
   logic                            out_vld_ff, out_vld_in;
   logic [vbmr_pkg::BRICK_IDX_W-1:0] out_bx_ff, out_by_ff, out_bz_ff;
   logic [vbmr_pkg::MAX_W-1:0]      out_max_ff;
   logic                            out_last_ff;

   logic                            out_free, s1_adv, accept, wr_en;
   logic [vbmr_pkg::MAX_W-1:0]      old_max, cur_max, new_max;

   always_comb begin
      out_free  = !out_vld_ff || rsp_ready;
      s1_adv    = s1_vld_ff && (!s1_ff.emit || out_free);
      req_ready = !s1_vld_ff || s1_adv;
      accept    = req_valid && req_ready;
      wr_en     = s1_adv && s1_ff.write;
      // write of the previous entry landed on the same edge as this read
      old_max   = (fwd_vld_ff && (fwd_addr_ff == s1_ff.addr)) ? fwd_data_ff : rd_data_ff;
      cur_max   = s1_ff.first ? '0 : old_max;
      new_max   = (s1_ff.dens > cur_max) ? s1_ff.dens : cur_max;
      s1_vld_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_ff);
      fwd_vld_in = accept ? wr_en : fwd_vld_ff;
      if (s1_adv && s1_ff.emit) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[s1_ff.addr] <= new_max;
      end
      if (accept) begin
         rd_data_ff <= mem[info.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         fwd_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         fwd_vld_ff <= fwd_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff       <= info;
         fwd_addr_ff <= s1_ff.addr;
         fwd_data_ff <= new_max;
      end
      if (s1_adv && s1_ff.emit) begin
         out_bx_ff   <= s1_ff.bx;
         out_by_ff   <= s1_ff.by;
         out_bz_ff   <= s1_ff.bz;
         out_max_ff  <= new_max;
         out_last_ff <= s1_ff.last;
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_brick_x        = out_bx_ff;
   assign rsp_brick_y        = out_by_ff;
   assign rsp_brick_z        = out_bz_ff;
   assign rsp_brick_max_bits = out_max_ff;
   assign rsp_last_brick     = out_last_ff;

endmodule

/* hdl/volume_brick_max_reduce_top.sv */
// Per-brick maximum of a raster-ordered density volume. One voxel transfer is taken
// every cycle unless a finished brick is held waiting on rsp_ready. A finished brick
// passes through the registered read of the 4096-entry brick-layer memory and the
// update stage after it, then waits in the output register. Forwarding of the
// just-written entry keeps back-to-back voxels of one brick at full rate.
// Entries need no clearing: the first voxel of a brick overwrites its slot.
// Any register write restarts the voxel position at the volume origin.
module volume_brick_max_reduce_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [vbmr_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [31:0]                          req_density_bits,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [vbmr_pkg::BRICK_IDX_W-1:0]     rsp_brick_x,
   output logic [vbmr_pkg::BRICK_IDX_W-1:0]     rsp_brick_y,
   output logic [vbmr_pkg::BRICK_IDX_W-1:0]     rsp_brick_z,
   output logic [vbmr_pkg::MAX_W-1:0]           rsp_brick_max_bits,
   output logic                                 rsp_last_brick
);

   vbmr_pkg::cfg_type        cfg_ff, cfg_in;
   vbmr_pkg::voxel_info_type info;
   logic                     csr_wr, accept;
   logic [1:0]               reg_idx;
   logic [5:0]               brick_clamped;
   logic [8:0]               dim_clamped;

   always_comb begin
      csr_wr  = csr_psel && csr_penable && csr_pwrite;
      reg_idx = csr_paddr[3:2];
      if (csr_pwdata < 32'(vbmr_pkg::MIN_BRICK)) begin
         brick_clamped = vbmr_pkg::MIN_BRICK;
      end else if (csr_pwdata > 32'(vbmr_pkg::MAX_BRICK)) begin
         brick_clamped = vbmr_pkg::MAX_BRICK;
      end else begin
         brick_clamped = csr_pwdata[5:0];
      end
      if (csr_pwdata < 32'(vbmr_pkg::MIN_DIM)) begin
         dim_clamped = vbmr_pkg::MIN_DIM;
      end else if (csr_pwdata > 32'(vbmr_pkg::MAX_DIM)) begin
         dim_clamped = vbmr_pkg::MAX_DIM;
      end else begin
         dim_clamped = csr_pwdata[8:0];
      end
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (reg_idx)
            vbmr_pkg::REG_BRICK_SIZE: cfg_in.brick_size = brick_clamped;
            vbmr_pkg::REG_DIM_X:      cfg_in.dim_x      = dim_clamped;
            vbmr_pkg::REG_DIM_Y:      cfg_in.dim_y      = dim_clamped;
            vbmr_pkg::REG_DIM_Z:      cfg_in.dim_z      = dim_clamped;
            default:                  cfg_in            = cfg_ff;
         endcase
      end
      case (reg_idx)
         vbmr_pkg::REG_BRICK_SIZE: csr_prdata = {26'd0, cfg_ff.brick_size};
         vbmr_pkg::REG_DIM_X:      csr_prdata = {23'd0, cfg_ff.dim_x};
         vbmr_pkg::REG_DIM_Y:      csr_prdata = {23'd0, cfg_ff.dim_y};
         vbmr_pkg::REG_DIM_Z:      csr_prdata = {23'd0, cfg_ff.dim_z};
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brick_size <= vbmr_pkg::RESET_BRICK;
         cfg_ff.dim_x      <= vbmr_pkg::MIN_DIM;
         cfg_ff.dim_y      <= vbmr_pkg::MIN_DIM;
         cfg_ff.dim_z      <= vbmr_pkg::MIN_DIM;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_pready = 1'b1;
   assign accept     = req_valid && req_ready;

   vbmr_walker u_walker (
      .clock        (clock),
      .reset        (reset),
      .restart      (csr_wr),
      .advance      (accept),
      .cfg          (cfg_ff),
      .density_bits (req_density_bits),
      .info         (info)
   );

   vbmr_reduce u_reduce (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .info               (info),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_brick_x        (rsp_brick_x),
      .rsp_brick_y        (rsp_brick_y),
      .rsp_brick_z        (rsp_brick_z),
      .rsp_brick_max_bits (rsp_brick_max_bits),
      .rsp_last_brick     (rsp_last_brick)
   );

endmodule

/* hdl/vbmr_checker.sv */
`include "volume_brick_max_reduce_top_assert.svh"

module vbmr_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [vbmr_pkg::BRICK_IDX_W-1:0]     rsp_brick_x,
   input logic [vbmr_pkg::BRICK_IDX_W-1:0]     rsp_brick_y,
   input logic [vbmr_pkg::BRICK_IDX_W-1:0]     rsp_brick_z,
   input logic [vbmr_pkg::MAX_W-1:0]           rsp_brick_max_bits,
   input logic                                 rsp_last_brick
);

   `VBMR_ASSERT_NOW(a_idle_after_reset, clock, 1'b0, $past(reset) && !reset, !rsp_valid && req_ready)

   `VBMR_ASSERT_NOW(a_max_not_nan, clock, reset, rsp_valid, rsp_brick_max_bits <= 31'h7F80_0000)

   `VBMR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   `VBMR_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready,
      $stable(rsp_brick_x) && $stable(rsp_brick_y) && $stable(rsp_brick_z) &&
      $stable(rsp_brick_max_bits) && $stable(rsp_last_brick))

endmodule

bind volume_brick_max_reduce_top vbmr_checker u_vbmr_checker (.*);

/* tb/sv/tb_volume_brick_max_reduce_top.sv */
`timescale 1ns / 1ps

module tb_volume_brick_max_reduce_top;

   localparam int unsigned BRICKS_PER_AXIS = 1 << vbmr_pkg::BRICK_IDX_W;
   localparam int unsigned RANDOM_ITEMS    = 1350;
   localparam int unsigned SETTLE_CYCLES   = 8;
   localparam int unsigned STREAM_CAP      = 300;
   localparam int unsigned SWAP_AT         = 450;
   localparam int unsigned NO_IDLE_AT      = 900;

   typedef struct packed {
      logic [vbmr_pkg::BRICK_IDX_W-1:0] bx;
      logic [vbmr_pkg::BRICK_IDX_W-1:0] by;
      logic [vbmr_pkg::BRICK_IDX_W-1:0] bz;
      logic [vbmr_pkg::MAX_W-1:0]       max_bits;
      logic                             last;
   } brick_result_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [vbmr_pkg::CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [31:0]                      csr_pwdata = '0;
   logic [31:0]                      csr_prdata;
   logic                             csr_pready;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [31:0]                      req_density_bits = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [vbmr_pkg::BRICK_IDX_W-1:0] rsp_brick_x;
   logic [vbmr_pkg::BRICK_IDX_W-1:0] rsp_brick_y;
   logic [vbmr_pkg::BRICK_IDX_W-1:0] rsp_brick_z;
   logic [vbmr_pkg::MAX_W-1:0]       rsp_brick_max_bits;
   logic                             rsp_last_brick;

   volume_brick_max_reduce_top dut (
      .clock              (clock),
      .reset              (reset),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_density_bits   (req_density_bits),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_brick_x        (rsp_brick_x),
      .rsp_brick_y        (rsp_brick_y),
      .rsp_brick_z        (rsp_brick_z),
      .rsp_brick_max_bits (rsp_brick_max_bits),
      .rsp_last_brick     (rsp_last_brick)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow configuration and stream position
   logic [5:0]                 cfg_brick = vbmr_pkg::RESET_BRICK;
   logic [8:0]                 cfg_dx = vbmr_pkg::MIN_DIM;
   logic [8:0]                 cfg_dy = vbmr_pkg::MIN_DIM;
   logic [8:0]                 cfg_dz = vbmr_pkg::MIN_DIM;
   logic [7:0]                 pos_x = '0, pos_y = '0, pos_z = '0;
   logic [4:0]                 off_x = '0, off_y = '0, off_z = '0;
   logic [vbmr_pkg::MAX_W-1:0] layer_max [vbmr_pkg::MEM_DEPTH];

   brick_result_type brick_expect_q[$];
   logic [31:0]      voxel_q[$];
   int unsigned      n_queued = 0;
   int unsigned      n_sent = 0;
   int unsigned      n_errors = 0;

   logic [31:0] directed_dens [24] = '{
      32'h8000_0000, 32'h7F80_0001, 32'hFFC0_0000, 32'hFFFF_FFFF,
      32'h0000_0001, 32'h8000_0001, 32'h3F80_0000, 32'h7F7F_FFFF,
      32'h7FFF_FFFF, 32'hFF80_0000, 32'h0000_0000, 32'h0000_0000,
      32'h7F80_0000, 32'h3F80_0000, 32'h7F80_0000, 32'h0000_0000,
      32'h7F80_0001, 32'h1234_5678, 32'h7F80_0000, 32'h8000_0000,
      32'h0000_0001, 32'h4049_0FDB, 32'hFFFF_FFFF, 32'h7F7F_FFFF
   };

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      n_errors++;
   endtask

   function automatic int unsigned bricks_along(input int unsigned dim, input int unsigned b);
      int unsigned n;
      n = (dim + b - 1) / b;
      if (n > BRICKS_PER_AXIS) n = BRICKS_PER_AXIS;
      return n;
   endfunction

   task automatic restart_position();
      pos_x = '0; pos_y = '0; pos_z = '0;
      off_x = '0; off_y = '0; off_z = '0;
   endtask

   function automatic logic [8:0] clamp_dim(input logic [31:0] v);
      if (v < vbmr_pkg::MIN_DIM) return vbmr_pkg::MIN_DIM;
      if (v > vbmr_pkg::MAX_DIM) return vbmr_pkg::MAX_DIM;
      return v[8:0];
   endfunction

   task automatic store_config(input logic [1:0] idx, input logic [31:0] v);
      case (idx)
         vbmr_pkg::REG_BRICK_SIZE: begin
            if (v < vbmr_pkg::MIN_BRICK) cfg_brick = vbmr_pkg::MIN_BRICK;
            else if (v > vbmr_pkg::MAX_BRICK) cfg_brick = vbmr_pkg::MAX_BRICK;
            else cfg_brick = v[5:0];
         end
         vbmr_pkg::REG_DIM_X: begin
            cfg_dx = clamp_dim(v);
         end
         vbmr_pkg::REG_DIM_Y: begin
            cfg_dy = clamp_dim(v);
         end
         default: begin
            cfg_dz = clamp_dim(v);
         end
      endcase
      restart_position();
   endtask

   task automatic reduce_voxel(input logic [31:0] bits);
      int unsigned                 b, bx, by, bz;
      logic [vbmr_pkg::ADDR_W-1:0] idx;
      bit                          row_end, col_end, vol_end, end_x, end_y, end_z, first;
      logic [31:0]                 cur;
      brick_result_type            r;
      b  = 32'(cfg_brick);
      bx = pos_x / b;
      by = pos_y / b;
      bz = pos_z / b;
      row_end = (pos_x + 1 >= cfg_dx);
      col_end = (pos_y + 1 >= cfg_dy);
      vol_end = (pos_z + 1 >= cfg_dz);
      end_x = row_end || (off_x + 1 >= b);
      end_y = col_end || (off_y + 1 >= b);
      end_z = vol_end || (off_z + 1 >= b);
      if (bx < BRICKS_PER_AXIS && by < BRICKS_PER_AXIS && bz < BRICKS_PER_AXIS) begin
         idx   = {by[vbmr_pkg::BRICK_IDX_W-1:0], bx[vbmr_pkg::BRICK_IDX_W-1:0]};
         first = (off_x == 0) && (off_y == 0) && (off_z == 0);
         cur   = first ? 32'd0 : {1'b0, layer_max[idx]};
         if (bits <= vbmr_pkg::POS_INF_BITS && bits > cur) cur = bits;
         layer_max[idx] = cur[vbmr_pkg::MAX_W-1:0];
         if (end_x && end_y && end_z) begin
            r.bx       = bx[vbmr_pkg::BRICK_IDX_W-1:0];
            r.by       = by[vbmr_pkg::BRICK_IDX_W-1:0];
            r.bz       = bz[vbmr_pkg::BRICK_IDX_W-1:0];
            r.max_bits = cur[vbmr_pkg::MAX_W-1:0];
            r.last     = (bx + 1 == bricks_along(32'(cfg_dx), b)) &&
                         (by + 1 == bricks_along(32'(cfg_dy), b)) &&
                         (bz + 1 == bricks_along(32'(cfg_dz), b));
            brick_expect_q.push_back(r);
         end
      end
      if (!row_end) begin
         pos_x = pos_x + 8'd1;
         off_x = (off_x + 1 >= b) ? 5'd0 : off_x + 5'd1;
      end else begin
         pos_x = '0;
         off_x = '0;
         if (!col_end) begin
            pos_y = pos_y + 8'd1;
            off_y = (off_y + 1 >= b) ? 5'd0 : off_y + 5'd1;
         end else begin
            pos_y = '0;
            off_y = '0;
            if (!vol_end) begin
               pos_z = pos_z + 8'd1;
               off_z = (off_z + 1 >= b) ? 5'd0 : off_z + 5'd1;
            end else begin
               pos_z = '0;
               off_z = '0;
            end
         end
      end
   endtask

   function automatic int unsigned send_idle_pct();
      if (n_sent < SWAP_AT) return 7;
      if (n_sent < NO_IDLE_AT) return 88;
      return 0;
   endfunction

   function automatic int unsigned recv_idle_pct();
      if (n_sent < SWAP_AT) return 88;
      if (n_sent < NO_IDLE_AT) return 7;
      return 0;
   endfunction

   function automatic logic [31:0] random_density();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'h0000_0000;
         2: return vbmr_pkg::POS_INF_BITS;
         3: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 23'h7F_FFFF))};
         4: return {1'b1, 31'($urandom())};
         5: return 32'h8000_0000;
         default: return {1'b0, 31'($urandom_range(0, 32'h7F7F_FFFF))};
      endcase
   endfunction

   // voxel driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            reduce_voxel(req_density_bits);
            n_sent++;
         end
         if (!req_valid || req_ready) begin
            if (voxel_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
               req_valid        <= 1'b1;
               req_density_bits <= voxel_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_brick();
      brick_result_type want;
      if (brick_expect_q.size() == 0) begin
         report_mismatch("brick with nothing pending",
                         {14'd0, rsp_brick_z, rsp_brick_y, rsp_brick_x}, '0);
      end else begin
         want = brick_expect_q.pop_front();
         if (rsp_brick_x !== want.bx)
            report_mismatch("brick_x", 32'(rsp_brick_x), 32'(want.bx));
         if (rsp_brick_y !== want.by)
            report_mismatch("brick_y", 32'(rsp_brick_y), 32'(want.by));
         if (rsp_brick_z !== want.bz)
            report_mismatch("brick_z", 32'(rsp_brick_z), 32'(want.bz));
         if (rsp_brick_max_bits !== want.max_bits)
            report_mismatch("brick_max_bits", 32'(rsp_brick_max_bits), 32'(want.max_bits));
         if (rsp_last_brick !== want.last)
            report_mismatch("last_brick", 32'(rsp_last_brick), 32'(want.last));
      end
   endtask

   // brick monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) check_brick();
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct());
      end
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      store_config(idx, value);
   endtask

   task automatic csr_read_check(input logic [1:0] idx, input logic [31:0] want);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) report_mismatch("register readback", csr_prdata, want);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic readback_config();
      csr_read_check(vbmr_pkg::REG_BRICK_SIZE, {26'd0, cfg_brick});
      csr_read_check(vbmr_pkg::REG_DIM_X, {23'd0, cfg_dx});
      csr_read_check(vbmr_pkg::REG_DIM_Y, {23'd0, cfg_dy});
      csr_read_check(vbmr_pkg::REG_DIM_Z, {23'd0, cfg_dz});
   endtask

   // all transfers done and pipeline drained
   task automatic settle();
      while (!(n_sent == n_queued && brick_expect_q.size() == 0)) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_volume(input logic [31:0] b, input logic [31:0] dx,
                                 input logic [31:0] dy, input logic [31:0] dz);
      settle();
      csr_write(vbmr_pkg::REG_BRICK_SIZE, b);
      csr_write(vbmr_pkg::REG_DIM_X, dx);
      csr_write(vbmr_pkg::REG_DIM_Y, dy);
      csr_write(vbmr_pkg::REG_DIM_Z, dz);
      readback_config();
   endtask

   task automatic push_voxel(input logic [31:0] bits);
      voxel_q.push_back(bits);
      n_queued++;
   endtask

   task automatic push_random(input int unsigned n);
      repeat (n) push_voxel(random_density());
   endtask

   initial begin
      int unsigned goal, vol, n;
      logic [31:0] b, dx, dy, dz;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      readback_config();

      // reset setting: every voxel is its own brick
      push_voxel(vbmr_pkg::POS_INF_BITS);
      push_voxel(32'h8000_0001);
      push_voxel(32'h3F80_0000);

      // brick size 0 clamps to the minimum; two volumes to see the wrap
      program_volume(32'd0, 32'd3, 32'd2, 32'd2);
      foreach (directed_dens[i]) push_voxel(directed_dens[i]);

      goal = n_queued + RANDOM_ITEMS;

      // long row past the brick limit, then tall and deep partial streams
      program_volume(32'd2, 32'h1FF, 32'd1, 32'd1);
      push_random(256);
      program_volume(32'd1000, 32'd1, 32'd256, 32'd1);
      push_random(96);
      program_volume(32'd32, 32'd0, 32'd1, 32'hFFFF_FFFF);
      push_random(96);

      while (n_queued < goal) begin
         b  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(2, 5);
         dx = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 8);
         dy = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 8);
         dz = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 8);
         program_volume(b, dx, dy, dz);
         vol = cfg_dx * cfg_dy * cfg_dz;
         case ($urandom_range(0, 3))
            0: n = 2 * vol;
            1: n = $urandom_range(1, vol);
            default: n = vol;
         endcase
         if (n > STREAM_CAP) n = STREAM_CAP;
         if (n > goal - n_queued) n = goal - n_queued;
         push_random(n);
      end

      settle();
      repeat (20) @(posedge clock);
      if (n_errors == 0) begin
         $display("[volume_brick_max_reduce_top] OK");
      end else begin
         $display("[volume_brick_max_reduce_top] ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("[volume_brick_max_reduce_top] ERROR");
      $finish;
   end

endmodule
